[rtl/tse_pkg.sv]
// Package for the tab stop expander: widths, register indexes, byte codes,
// reset values and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tse_pkg;

  localparam int unsigned NUM_STOPS     = 6;   // explicit stops taken into account
  localparam int unsigned NUM_STOP_REGS = 6;   // stop registers in the map
  localparam int unsigned MAX_GAP       = 64;  // most spaces one tab may emit

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned STOP_W     = 9;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned DW_W       = 7;
  localparam int unsigned GAP_W      = $clog2(MAX_GAP + 1);
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned STOP_SEL_W = (NUM_STOP_REGS > 1) ? $clog2(NUM_STOP_REGS) : 1;

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP_A        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_F        = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_WIDTH = 3'd7;

  localparam logic [STOP_W-1:0] STOP_MASK [NUM_STOP_REGS] =
    '{9'h07F, 9'h0FF, 9'h0FF, 9'h1FF, 9'h1FF, 9'h1FF};
  localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOP_REGS] =
    '{9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48};
  localparam logic [DW_W-1:0]   DW_RESET = 7'd8;

  // Byte codes
  localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] BYTE_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;

  localparam logic [COL_W-1:0]  COL_MAX = '1;

  typedef struct packed {
    logic load_byte;   // capture the accepted request
    logic search;      // register the explicit stop search
    logic div_start;   // start the default stop remainder
    logic load_gap;    // set the space count and advance the column
    logic emit_byte;   // pass the held byte to the output register
    logic emit_space;  // push one space to the output register
  } tse_cmd_t;

  typedef struct packed {
    logic in_tab;      // byte on the input channel is a tab
    logic found;       // an explicit stop lies past the column
    logic div_done;    // remainder ready
    logic out_free;    // output register can load this cycle
    logic space_last;  // next space is the final one of the tab
  } tse_status_t;

endpackage

`default_nettype wire

[rtl/tse_if.sv]
// Valid/ready channel interfaces for the tab stop expander: text byte in,
// text byte plus end marker out. Depends on tse_pkg.
`default_nettype none

interface tse_in_if;
  logic                       valid;
  logic                       ready;
  logic [tse_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tse_out_if;
  logic                       valid;
  logic                       ready;
  logic [tse_pkg::BYTE_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/tab_stop_expander_core.sv]
// Tab stop expander top level: joins controller and datapath to the channels.
// Depends on tse_pkg, tse_if, tse_ctrl and tse_datapath.
//
// Usage: text bytes arrive on in_if, one request per byte. Every byte but a
// tab leaves on out_if unchanged with last set. A tab leaves as 1 to 64
// spaces up to the next tab stop, last set on the final space. Stops are the
// first stop_count of registers stop_a..stop_f, then every default_width
// columns past the largest of them. A newline returns the column to zero.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while
// idle; the user must keep to this, as the block does not enforce it. A plain
// byte is accepted, then loaded into the output register once that is free.
// A tab is accepted and its stop search registered; a tab to an explicit stop
// then loads its gap, while a tab to a default stop first runs the bit-serial
// remainder unit. The spaces follow one per cycle while the output is free.
// One byte is worked on at a time; the next request is taken as soon as the
// last result sits in the output register, even if it is still unread.
// A stalled receiver holds the output register and halts the space count.
// Reset empties the output register, sets the column to zero and loads the
// register reset values; no clearing pass is needed.
`default_nettype none

module tab_stop_expander_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tse_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tse_in_if.sink                        in_if,
  tse_out_if.source                     out_if
);
  import tse_pkg::*;

  tse_cmd_t    cmd;
  tse_status_t status;

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_if.in_byte),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_byte_o  (out_if.out_byte),
    .out_last_o  (out_if.last),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

[rtl/tse_rem.sv]
// Bit-serial remainder unit: column offset modulo the default stop spacing,
// one dividend bit per cycle. Depends on tse_pkg.
`default_nettype none

module tse_rem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tse_pkg::COL_W-1:0] dividend_i,
  input  logic [tse_pkg::DW_W-1:0]  divisor_i,
  output logic                     done_o,
  output logic [tse_pkg::DW_W-1:0]  rem_o
);
  import tse_pkg::*;

  localparam int unsigned BIT_CNT_W = $clog2(COL_W);

  logic                 busy_q, done_q;
  logic [BIT_CNT_W-1:0] bit_q;
  logic [COL_W-1:0]     dvd_q;
  logic [DW_W-1:0]      div_q, rem_q;
  logic [DW_W:0]        trial;
  logic [DW_W-1:0]      rem_d;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[COL_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = DW_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[DW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= BIT_CNT_W'(COL_W - 1);
      end else if (busy_q) begin
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[COL_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

[rtl/tse_datapath.sv]
// Datapath of the tab stop expander: configuration registers, column counter,
// stop search, gap computation, space counter and output register.
// Depends on tse_pkg and tse_rem.
`default_nettype none

module tse_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tse_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [tse_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tse_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                          out_last_o,
  input  tse_pkg::tse_cmd_t              cmd_i,
  output tse_pkg::tse_status_t           status_o
);
  import tse_pkg::*;

  // Configuration
  logic [CNT_W-1:0]  stop_count_q;
  logic [STOP_W-1:0] stop_q [NUM_STOP_REGS];
  logic [DW_W-1:0]   dw_q;
  logic [STOP_SEL_W-1:0] stop_sel;

  assign stop_sel = STOP_SEL_W'(cfg_idx_i - REG_STOP_A);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= '0;
      dw_q         <= DW_RESET;
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        stop_q[k] <= STOP_RESET[k];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_STOP_COUNT:          stop_count_q     <= cfg_wdata_i[CNT_W-1:0];
        [REG_STOP_A:REG_STOP_F]: stop_q[stop_sel] <= cfg_wdata_i & STOP_MASK[stop_sel];
        REG_DEFAULT_WIDTH:       dw_q             <= cfg_wdata_i[DW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0]  column_q;

  // Explicit stop search: nearest used stop past the column, and the largest one
  logic [CNT_W-1:0]  n_used;
  logic              srch_found;
  logic [STOP_W-1:0] srch_best, srch_top;

  always_comb begin
    n_used     = (stop_count_q > CNT_W'(NUM_STOPS)) ? CNT_W'(NUM_STOPS) : stop_count_q;
    srch_found = 1'b0;
    srch_best  = '0;
    srch_top   = '0;
    for (int k = 0; k < NUM_STOPS; k++) begin
      if (CNT_W'(k) < n_used) begin
        if (stop_q[k] > srch_top) begin
          srch_top = stop_q[k];
        end
        if ({{(COL_W-STOP_W){1'b0}}, stop_q[k]} > column_q &&
            (!srch_found || stop_q[k] < srch_best)) begin
          srch_best  = stop_q[k];
          srch_found = 1'b1;
        end
      end
    end
  end

  logic              found_q;
  logic [STOP_W-1:0] best_q, top_q;
  logic [BYTE_W-1:0] byte_q;
  logic [GAP_W-1:0]  cnt_q;

  // Default stop spacing, clamped to 1..MAX_GAP
  logic [DW_W-1:0] dw_eff;
  always_comb begin
    if (dw_q == '0) begin
      dw_eff = DW_W'(1);
    end else if (dw_q > DW_W'(MAX_GAP)) begin
      dw_eff = DW_W'(MAX_GAP);
    end else begin
      dw_eff = dw_q;
    end
  end

  logic            rem_done;
  logic [DW_W-1:0] rem;

  tse_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (column_q - {{(COL_W-STOP_W){1'b0}}, top_q}),
    .divisor_i  (dw_eff),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Gap to the chosen stop
  logic [COL_W-1:0] expl_diff;
  logic [GAP_W-1:0] expl_gap, dflt_gap, gap_new;
  logic [COL_W:0]   col_sum;
  logic [COL_W-1:0] col_tab;

  always_comb begin
    expl_diff = {{(COL_W-STOP_W){1'b0}}, best_q} - column_q;
    expl_gap  = (expl_diff > COL_W'(MAX_GAP)) ? GAP_W'(MAX_GAP) : expl_diff[GAP_W-1:0];
    dflt_gap  = GAP_W'(dw_eff) - GAP_W'(rem);
    gap_new   = found_q ? expl_gap : dflt_gap;
    col_sum   = {1'b0, column_q} + (COL_W+1)'(gap_new);
    col_tab   = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
  end

  // Column and output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_gap) begin
        column_q <= col_tab;
      end else if (cmd_i.emit_byte) begin
        if (byte_q == BYTE_NL) begin
          column_q <= '0;
        end else if (column_q != COL_MAX) begin
          column_q <= column_q + 1'b1;
        end
      end
      if (cmd_i.emit_byte || cmd_i.emit_space) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.search) begin
      found_q <= srch_found;
      best_q  <= srch_best;
      top_q   <= srch_top;
    end
    if (cmd_i.load_gap) begin
      cnt_q <= gap_new;
    end else if (cmd_i.emit_space) begin
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.emit_byte) begin
      out_byte_q <= byte_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_space) begin
      out_byte_q <= BYTE_SPACE;
      out_last_q <= (cnt_q == GAP_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign status_o.in_tab     = (in_byte_i == BYTE_TAB);
  assign status_o.found      = found_q;
  assign status_o.div_done   = rem_done;
  assign status_o.out_free   = out_free;
  assign status_o.space_last = (cnt_q == GAP_W'(1));

  a_gap_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_gap |=> (cnt_q != '0 && cnt_q <= GAP_W'(MAX_GAP)))
    else $error("tab gap out of range");

  a_space_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_space |-> (cnt_q != '0))
    else $error("space emitted with empty count");

endmodule

`default_nettype wire

[rtl/tse_ctrl.sv]
// Controller of the tab stop expander: sequences request capture, stop search,
// remainder, and space or byte emission. Depends on tse_pkg.
`default_nettype none

module tse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tse_pkg::tse_status_t  status_i,
  output tse_pkg::tse_cmd_t     cmd_o
);
  import tse_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHOOSE,
    ST_DIVIDE,
    ST_SPACE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_o.load_byte = 1'b1;
          state_d = status_i.in_tab ? ST_SEARCH : ST_EMIT;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d = ST_CHOOSE;
      end
      ST_CHOOSE: begin
        if (status_i.found) begin
          cmd_o.load_gap = 1'b1;
          state_d = ST_SPACE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.load_gap = 1'b1;
          state_d = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (status_i.out_free) begin
          cmd_o.emit_space = 1'b1;
          if (status_i.space_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_plain_byte_to_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !status_i.in_tab) |=> (state_q == ST_EMIT))
    else $error("plain byte did not go to emit");

endmodule

`default_nettype wire
